// ===== rtl/core/convex_polygon_halfplane_clip_top_assert.svh =====
// Assertion macros for the half-plane clipper.
`ifndef CONVEX_POLYGON_HALFPLANE_CLIP_TOP_ASSERT_SVH
`define CONVEX_POLYGON_HALFPLANE_CLIP_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CPHC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cphc assertion failed");
`define CPHC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cphc assertion failed");
`else
`define CPHC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CPHC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/core/cphc_pkg.sv =====
package cphc_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int FIELD_W         = 32;
  localparam int REG_IDX_W       = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_LINE_AX = 2'd0,
    REG_LINE_AY = 2'd1,
    REG_LINE_BX = 2'd2,
    REG_LINE_BY = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vertex_x;
    logic signed [FIELD_W-1:0] vertex_y;
    logic                      vertex_last;
  } vertex_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic                      is_intersection;
    logic                      result_last;
    logic                      polygon_empty;
  } result_t;

endpackage

// ===== rtl/core/convex_polygon_halfplane_clip_top.sv =====
// Clips a streamed polygon against the half-plane left of (or on) the directed line A->B
// held in the four line registers, one Sutherland-Hodgman stage. One vertex beat is taken
// at a time and vertex_stall stays high until its work is done. All arithmetic runs through
// one shared (COORD_WIDTH+1)-bit signed multiplier with a 3*COORD_WIDTH+3 bit accumulator
// and one restoring divider giving one quotient bit per cycle. An edge with no crossing
// needs 4 products for the two side tests; an edge that crosses the line adds up to 14
// products and, when the determinant is nonzero, two divisions. The vertex that closes a
// polygon also walks the closing edge. Results leave through one output register; the
// block waits while that register is full and stalled. Results lag by one so that
// result_last marks the true final vertex; an empty clip gives a single beat with
// polygon_empty and result_last set and zero coordinates.
`include "convex_polygon_halfplane_clip_top_assert.svh"

module convex_polygon_halfplane_clip_top #(
  parameter int COORD_WIDTH = cphc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = cphc_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [cphc_pkg::REG_IDX_W-1:0]          cfg_index,
  input  logic [cphc_pkg::FIELD_W-1:0]            cfg_data,
  input  logic                                    vertex_valid,
  output logic                                    vertex_stall,
  input  cphc_pkg::vertex_t                       vertex,
  output logic                                    result_valid,
  input  logic                                    result_stall,
  output cphc_pkg::result_t                       result
);
  import cphc_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int MW   = CW + 1;
  localparam int PW   = 2 * MW;
  localparam int CXW  = 2 * CW + 1;
  localparam int DW   = 2 * CW + 3;
  localparam int AW   = 3 * CW + 3;
  localparam int RW   = DW + 1;
  localparam int CNTW = $clog2(AW);
  localparam int TW   = 5;

  localparam logic [FIELD_W-1:0] ONE_FIX = FIELD_W'(1) << FRAC_BITS;

  localparam logic [TW-1:0] T_SIDE_P_END = TW'(1);
  localparam logic [TW-1:0] T_SIDE_Q_END = TW'(3);
  localparam logic [TW-1:0] T_CROSS_BEG  = TW'(4);
  localparam logic [TW-1:0] T_C1_END     = TW'(5);
  localparam logic [TW-1:0] T_C2_END     = TW'(7);
  localparam logic [TW-1:0] T_DET_END    = TW'(9);
  localparam logic [TW-1:0] T_NX_END     = TW'(13);
  localparam logic [TW-1:0] T_NY_END     = TW'(17);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_MUL      = 10'b0000000010,
    S_ACC      = 10'b0000000100,
    S_PUSHV    = 10'b0000001000,
    S_CROSS    = 10'b0000010000,
    S_DIVLD    = 10'b0000100000,
    S_DIVRUN   = 10'b0001000000,
    S_PUSHI    = 10'b0010000000,
    S_EDGE_END = 10'b0100000000,
    S_FINAL    = 10'b1000000000
  } state_t;

  state_t state;

  logic signed [CW-1:0]  line_ax, line_ay, line_bx, line_by;
  logic signed [CW-1:0]  first_x, first_y, prev_x, prev_y;
  logic signed [CW-1:0]  in_x, in_y, ep_x, ep_y, eq_x, eq_y;
  logic                  in_last, edge_close, have_first, any_emitted;
  logic signed [CW-1:0]  pend_x, pend_y, qx, qy;
  logic                  pend_isect;
  logic                  sp_neg, sp_nz, sq_neg, sq_nz;
  logic [TW-1:0]         term;
  logic signed [PW-1:0]  prod;
  logic signed [AW-1:0]  acc, nx, ny;
  logic signed [CXW-1:0] c1, c2;
  logic signed [DW-1:0]  det;
  logic                  div_y, div_neg, div_ovf;
  logic [AW-1:0]         div_num;
  logic [DW-1:0]         div_den, div_rem;
  logic [CW-1:0]         div_q;
  logic [CNTW-1:0]       div_cnt;

  // shared multiplier operand selection
  logic signed [MW-1:0] op_a, op_b;
  logic                 op_neg, op_hi, op_clr;
  logic signed [MW-1:0] dbax, dbay, dpax, dpay, dqax, dqay, a1, b1, a2;
  logic signed [MW-1:0] c1lo, c1hi, c2lo, c2hi;

  assign dbax = MW'(line_bx) - MW'(line_ax);
  assign dbay = MW'(line_by) - MW'(line_ay);
  assign dpax = MW'(ep_x) - MW'(line_ax);
  assign dpay = MW'(ep_y) - MW'(line_ay);
  assign dqax = MW'(eq_x) - MW'(line_ax);
  assign dqay = MW'(eq_y) - MW'(line_ay);
  assign a1   = MW'(ep_y) - MW'(eq_y);
  assign b1   = MW'(eq_x) - MW'(ep_x);
  assign a2   = MW'(line_ay) - MW'(line_by);
  assign c1lo = signed'({1'b0, c1[CW-1:0]});
  assign c1hi = signed'(c1[CXW-1:CW]);
  assign c2lo = signed'({1'b0, c2[CW-1:0]});
  assign c2hi = signed'(c2[CXW-1:CW]);

  always_comb begin
    op_a = dbax; op_b = dpay; op_neg = 1'b0; op_hi = 1'b0; op_clr = 1'b0;
    case (term)
      5'd0:  begin op_a = dbax; op_b = dpay; op_clr = 1'b1; end
      5'd1:  begin op_a = dbay; op_b = dpax; op_neg = 1'b1; end
      5'd2:  begin op_a = dbax; op_b = dqay; op_clr = 1'b1; end
      5'd3:  begin op_a = dbay; op_b = dqax; op_neg = 1'b1; end
      5'd4:  begin op_a = MW'(ep_x); op_b = MW'(eq_y); op_clr = 1'b1; end
      5'd5:  begin op_a = MW'(ep_y); op_b = MW'(eq_x); op_neg = 1'b1; end
      5'd6:  begin op_a = MW'(line_ax); op_b = MW'(line_by); op_clr = 1'b1; end
      5'd7:  begin op_a = MW'(line_ay); op_b = MW'(line_bx); op_neg = 1'b1; end
      5'd8:  begin op_a = a1; op_b = dbax; op_clr = 1'b1; end
      5'd9:  begin op_a = a2; op_b = b1; op_neg = 1'b1; end
      5'd10: begin op_a = b1; op_b = c2lo; op_clr = 1'b1; end
      5'd11: begin op_a = b1; op_b = c2hi; op_hi = 1'b1; end
      5'd12: begin op_a = dbax; op_b = c1lo; op_neg = 1'b1; end
      5'd13: begin op_a = dbax; op_b = c1hi; op_neg = 1'b1; op_hi = 1'b1; end
      5'd14: begin op_a = a2; op_b = c1lo; op_clr = 1'b1; end
      5'd15: begin op_a = a2; op_b = c1hi; op_hi = 1'b1; end
      5'd16: begin op_a = a1; op_b = c2lo; op_neg = 1'b1; end
      5'd17: begin op_a = a1; op_b = c2hi; op_neg = 1'b1; op_hi = 1'b1; end
      default: begin op_a = dbax; op_b = dpay; end
    endcase
  end

  logic signed [AW-1:0] t_ext, t_sh, acc_next;
  logic                 acc_neg, acc_nz;

  assign t_ext    = AW'(prod);
  assign t_sh     = op_hi ? (t_ext <<< CW) : t_ext;
  assign acc_next = (op_clr ? '0 : acc) + (op_neg ? -t_sh : t_sh);
  assign acc_neg  = acc_next[AW-1];
  assign acc_nz   = (acc_next != '0);

  // restoring divider step
  logic [RW-1:0] r2, r_new;
  logic          ge, ovf_fin;
  logic [CW-1:0] q_fin, lim, mag, div_res;
  logic signed [AW-1:0] n_src;

  assign r2      = {div_rem, div_num[AW-1]};
  assign ge      = (r2 >= {1'b0, div_den});
  assign r_new   = ge ? (r2 - {1'b0, div_den}) : r2;
  assign q_fin   = {div_q[CW-2:0], ge};
  assign ovf_fin = div_ovf | div_q[CW-1];
  assign lim     = {div_neg, {(CW-1){~div_neg}}};
  assign mag     = (ovf_fin || (q_fin > lim)) ? lim : q_fin;
  assign div_res = div_neg ? -mag : mag;
  assign n_src   = div_y ? ny : nx;

  // output register and push path
  logic can_put, put_fire, push_go, crossing;
  result_t put_data;

  assign can_put  = !result_valid || !result_stall;
  assign push_go  = !any_emitted || can_put;
  assign crossing = (!sp_neg && sp_nz && sq_neg) || (sp_neg && !sq_neg && sq_nz);

  always_comb begin
    put_fire = 1'b0;
    put_data.out_x           = FIELD_W'(pend_x);
    put_data.out_y           = FIELD_W'(pend_y);
    put_data.is_intersection = pend_isect;
    put_data.result_last     = 1'b0;
    put_data.polygon_empty   = 1'b0;
    unique case (state)
      S_PUSHV, S_PUSHI: put_fire = push_go && any_emitted;
      S_FINAL: begin
        put_fire = can_put;
        put_data.result_last = 1'b1;
        if (!any_emitted) begin
          put_data.out_x         = '0;
          put_data.out_y         = '0;
          put_data.polygon_empty = 1'b1;
        end
      end
      default: put_fire = 1'b0;
    endcase
  end

  assign vertex_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (put_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (put_fire) begin
      result <= put_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      have_first  <= 1'b0;
      any_emitted <= 1'b0;
      line_ax     <= '0;
      line_ay     <= '0;
      line_bx     <= ONE_FIX[CW-1:0];
      line_by     <= '0;
      term        <= '0;
    end else begin
      if (cfg_write) begin
        unique case (reg_idx_t'(cfg_index))
          REG_LINE_AX: line_ax <= cfg_data[CW-1:0];
          REG_LINE_AY: line_ay <= cfg_data[CW-1:0];
          REG_LINE_BX: line_bx <= cfg_data[CW-1:0];
          REG_LINE_BY: line_by <= cfg_data[CW-1:0];
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (vertex_valid) begin
            in_x    <= vertex.vertex_x[CW-1:0];
            in_y    <= vertex.vertex_y[CW-1:0];
            in_last <= vertex.vertex_last;
            prev_x  <= vertex.vertex_x[CW-1:0];
            prev_y  <= vertex.vertex_y[CW-1:0];
            term    <= '0;
            eq_x    <= vertex.vertex_x[CW-1:0];
            eq_y    <= vertex.vertex_y[CW-1:0];
            if (!have_first) begin
              first_x    <= vertex.vertex_x[CW-1:0];
              first_y    <= vertex.vertex_y[CW-1:0];
              have_first <= 1'b1;
              ep_x       <= vertex.vertex_x[CW-1:0];
              ep_y       <= vertex.vertex_y[CW-1:0];
              edge_close <= 1'b1;
              if (vertex.vertex_last) state <= S_MUL;
            end else begin
              ep_x       <= prev_x;
              ep_y       <= prev_y;
              edge_close <= 1'b0;
              state      <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod  <= op_a * op_b;
          state <= S_ACC;
        end
        S_ACC: begin
          acc  <= acc_next;
          term <= term + TW'(1);
          if (term == T_SIDE_P_END) begin
            sp_neg <= acc_neg;
            sp_nz  <= acc_nz;
            state  <= S_MUL;
          end else if (term == T_SIDE_Q_END) begin
            sq_neg <= acc_neg;
            sq_nz  <= acc_nz;
            state  <= sp_neg ? S_CROSS : S_PUSHV;
          end else if (term == T_C1_END) begin
            c1    <= acc_next[CXW-1:0];
            state <= S_MUL;
          end else if (term == T_C2_END) begin
            c2    <= acc_next[CXW-1:0];
            state <= S_MUL;
          end else if (term == T_DET_END) begin
            det   <= acc_next[DW-1:0];
            state <= acc_nz ? S_MUL : S_EDGE_END;
          end else if (term == T_NX_END) begin
            nx    <= acc_next;
            state <= S_MUL;
          end else if (term == T_NY_END) begin
            ny    <= acc_next;
            div_y <= 1'b0;
            state <= S_DIVLD;
          end else begin
            state <= S_MUL;
          end
        end
        S_PUSHV: begin
          if (push_go) begin
            pend_x      <= ep_x;
            pend_y      <= ep_y;
            pend_isect  <= 1'b0;
            any_emitted <= 1'b1;
            state       <= S_CROSS;
          end
        end
        S_CROSS: begin
          if (crossing) begin
            term  <= T_CROSS_BEG;
            state <= S_MUL;
          end else begin
            state <= S_EDGE_END;
          end
        end
        S_DIVLD: begin
          div_num <= n_src[AW-1] ? AW'(-n_src) : AW'(n_src);
          div_den <= det[DW-1] ? DW'(-det) : DW'(det);
          div_neg <= n_src[AW-1] ^ det[DW-1];
          div_rem <= '0;
          div_q   <= '0;
          div_ovf <= 1'b0;
          div_cnt <= CNTW'(AW - 1);
          state   <= S_DIVRUN;
        end
        S_DIVRUN: begin
          div_rem <= r_new[DW-1:0];
          div_num <= div_num << 1;
          div_q   <= q_fin;
          div_ovf <= ovf_fin;
          div_cnt <= div_cnt - CNTW'(1);
          if (div_cnt == '0) begin
            if (!div_y) begin
              qx    <= div_res;
              div_y <= 1'b1;
              state <= S_DIVLD;
            end else begin
              qy    <= div_res;
              state <= S_PUSHI;
            end
          end
        end
        S_PUSHI: begin
          if (push_go) begin
            pend_x      <= qx;
            pend_y      <= qy;
            pend_isect  <= 1'b1;
            any_emitted <= 1'b1;
            state       <= S_EDGE_END;
          end
        end
        S_EDGE_END: begin
          if (in_last && !edge_close) begin
            ep_x       <= in_x;
            ep_y       <= in_y;
            eq_x       <= first_x;
            eq_y       <= first_y;
            edge_close <= 1'b1;
            term       <= '0;
            state      <= S_MUL;
          end else if (in_last) begin
            state <= S_FINAL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_FINAL: begin
          if (can_put) begin
            have_first  <= 1'b0;
            any_emitted <= 1'b0;
            pend_x      <= '0;
            pend_y      <= '0;
            pend_isect  <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CPHC_ASSERT_IMP(a_put_slot_free, clk, rst, put_fire, can_put)
  `CPHC_ASSERT_IMP(a_div_nonzero, clk, rst, state == S_DIVRUN, det != '0)
  `CPHC_ASSERT_IMP(a_empty_marker, clk, rst, result_valid && result.polygon_empty, result.result_last && !result.is_intersection && result.out_x == '0 && result.out_y == '0)
  `CPHC_ASSERT_NXT(a_open_after_beat, clk, rst, vertex_valid && !vertex_stall, have_first || state != S_IDLE)

endmodule

// ===== dv/convex_polygon_halfplane_clip_top_tb.sv =====
module convex_polygon_halfplane_clip_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cphc_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int  SETTLE_CYCLES = 600;
  localparam int  CYCLE_LIMIT   = 1000000;
  localparam longint COORD_MAX  = 64'sd2147483647;
  localparam longint COORD_MIN  = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0] cfg_data = '0;
  logic vertex_valid = 1'b0;
  logic vertex_stall;
  vertex_t vertex = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  convex_polygon_halfplane_clip_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .vertex_valid(vertex_valid), .vertex_stall(vertex_stall), .vertex(vertex),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #5 clk = ~clk;

  // clip line and walker state
  longint ln_ax, ln_ay, ln_bx, ln_by;
  longint first_x, first_y, prev_x, prev_y;
  bit open_poly, held_valid, held_isect;
  longint held_x, held_y;

  vertex_t pending_vertices[$];
  result_t expected_results[$];
  bit idle_on = 1'b1;
  int errors = 0;
  int cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;

  function automatic int line_side(longint px, longint py);
    wide_t t;
    t = wide_t'(ln_bx - ln_ax) * wide_t'(py - ln_ay) - wide_t'(ln_by - ln_ay) * wide_t'(px - ln_ax);
    return (t < 0) ? -1 : (t != 0) ? 1 : 0;
  endfunction

  function automatic longint quot_sat(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if (q > COORD_MAX) return COORD_MAX;
    if (q < COORD_MIN) return COORD_MIN;
    return longint'(q);
  endfunction

  function automatic void emit(longint x, longint y, bit last, bit empty, bit isect);
    result_t r;
    r.out_x = x[31:0];
    r.out_y = y[31:0];
    r.is_intersection = isect;
    r.result_last = last;
    r.polygon_empty = empty;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void hold(longint x, longint y, bit isect);
    if (held_valid) emit(held_x, held_y, 1'b0, 1'b0, held_isect);
    held_x = x;
    held_y = y;
    held_isect = isect;
    held_valid = 1'b1;
  endfunction

  function automatic void clip_edge(longint px, longint py, longint qx, longint qy);
    int sp, sq;
    wide_t a1, b1, c1, a2, b2, c2, det, nx, ny;
    sp = line_side(px, py);
    sq = line_side(qx, qy);
    if (sp >= 0) hold(px, py, 1'b0);
    if ((sp > 0 && sq < 0) || (sp < 0 && sq > 0)) begin
      a1 = wide_t'(py - qy);
      b1 = wide_t'(qx - px);
      c1 = wide_t'(px) * wide_t'(qy) - wide_t'(py) * wide_t'(qx);
      a2 = wide_t'(ln_ay - ln_by);
      b2 = wide_t'(ln_bx - ln_ax);
      c2 = wide_t'(ln_ax) * wide_t'(ln_by) - wide_t'(ln_ay) * wide_t'(ln_bx);
      det = a1 * b2 - a2 * b1;
      if (det != 0) begin
        nx = b1 * c2 - b2 * c1;
        ny = c1 * a2 - a1 * c2;
        hold(quot_sat(nx, det), quot_sat(ny, det), 1'b1);
      end
    end
  endfunction

  function automatic void clip_vertex(vertex_t v);
    longint vx, vy;
    vx = longint'(v.vertex_x);
    vy = longint'(v.vertex_y);
    if (!open_poly) begin
      first_x = vx;
      first_y = vy;
      open_poly = 1'b1;
    end else begin
      clip_edge(prev_x, prev_y, vx, vy);
    end
    prev_x = vx;
    prev_y = vy;
    if (v.vertex_last) begin
      clip_edge(vx, vy, first_x, first_y);
      if (held_valid) emit(held_x, held_y, 1'b1, 1'b0, held_isect);
      else emit(0, 0, 1'b1, 1'b1, 1'b0);
      open_poly = 1'b0;
      held_valid = 1'b0;
    end
  endfunction

  // vertex driver
  always @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
    end else begin
      if (vertex_valid && !vertex_stall) clip_vertex(vertex);
      if (!vertex_valid || !vertex_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          vertex_valid <= 1'b0;
        end else if (pending_vertices.size() > 0 && idle_on && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(0, 2);
          vertex_valid <= 1'b0;
        end else if (pending_vertices.size() > 0) begin
          vertex <= pending_vertices.pop_front();
          vertex_valid <= 1'b1;
        end else begin
          vertex_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat x=%0d y=%0d", result.out_x, result.out_y);
          errors++;
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (result.out_x !== e.out_x) begin
            $error("out_x expected %0d got %0d", e.out_x, result.out_x);
            errors++;
          end
          if (result.out_y !== e.out_y) begin
            $error("out_y expected %0d got %0d", e.out_y, result.out_y);
            errors++;
          end
          if (result.is_intersection !== e.is_intersection) begin
            $error("is_intersection expected %0b got %0b", e.is_intersection,
                   result.is_intersection);
            errors++;
          end
          if (result.result_last !== e.result_last) begin
            $error("result_last expected %0b got %0b", e.result_last, result.result_last);
            errors++;
          end
          if (result.polygon_empty !== e.polygon_empty) begin
            $error("polygon_empty expected %0b got %0b", e.polygon_empty, result.polygon_empty);
            errors++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        result_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 2);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_t idx, longint val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[31:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_LINE_AX: ln_ax = longint'($signed(val[31:0]));
      REG_LINE_AY: ln_ay = longint'($signed(val[31:0]));
      REG_LINE_BX: ln_bx = longint'($signed(val[31:0]));
      default:     ln_by = longint'($signed(val[31:0]));
    endcase
  endtask

  task automatic set_line(longint ax, longint ay, longint bx, longint by);
    write_reg(REG_LINE_AX, ax);
    write_reg(REG_LINE_AY, ay);
    write_reg(REG_LINE_BX, bx);
    write_reg(REG_LINE_BY, by);
  endtask

  task automatic put_vertex(longint x, longint y, bit last);
    vertex_t v;
    v.vertex_x = x[31:0];
    v.vertex_y = y[31:0];
    v.vertex_last = last;
    pending_vertices.insert(pending_vertices.size(), v);
  endtask

  function automatic longint pick_coord(bit wide_range);
    if (wide_range || $urandom_range(0, 9) == 0) return longint'($signed($urandom()));
    return longint'($urandom_range(0, 13107200)) - 64'sd6553600;
  endfunction

  task automatic put_polygon(int n, bit wide_range);
    for (int k = 0; k < n; k++)
      put_vertex(pick_coord(wide_range), pick_coord(wide_range), k == n - 1);
  endtask

  task automatic drain();
    while (pending_vertices.size() > 0 || vertex_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    ln_ax = 0; ln_ay = 0; ln_bx = 65536; ln_by = 0;
    open_poly = 0; held_valid = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset line (x axis, keep y >= 0)
    put_vertex(0, 0, 1'b1);
    put_vertex(100, -100, 1'b1);
    put_vertex(-65536, 65536, 1'b0);
    put_vertex(65536, 65536, 1'b0);
    put_vertex(65536, -65536, 1'b0);
    put_vertex(-65536, -65536, 1'b1);
    put_vertex(-5, -5, 1'b0);
    put_vertex(5, -7, 1'b1);
    put_vertex(COORD_MAX, COORD_MAX, 1'b0);
    put_vertex(COORD_MIN, COORD_MIN, 1'b0);
    put_vertex(COORD_MIN, COORD_MAX, 1'b1);
    put_vertex(32'h5555_5555, 32'h2AAA_AAAA, 1'b0);
    put_vertex(32'hAAAA_AAAA, 32'hD555_5555, 1'b1);
    drain();

    // degenerate line
    set_line(65536, -65536, 65536, -65536);
    put_vertex(COORD_MIN, 0, 1'b0);
    put_vertex(0, COORD_MAX, 1'b0);
    put_vertex(COORD_MAX, COORD_MIN, 1'b1);
    drain();

    // nearly parallel edge, crossing far out of range
    set_line(COORD_MIN, -1, COORD_MAX, 1);
    put_vertex(COORD_MIN, 0, 1'b0);
    put_vertex(COORD_MAX, 3, 1'b1);
    put_vertex(COORD_MIN, COORD_MAX, 1'b0);
    put_vertex(COORD_MAX, COORD_MIN, 1'b1);
    drain();

    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_line(0, 0, 65536, 0);
        1: set_line(pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0));
        2: set_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        3: set_line(longint'($signed($urandom())), longint'($signed($urandom())),
                    longint'($signed($urandom())), longint'($signed($urandom())));
        4: set_line(0, 0, 0, 0);
        5: set_line(pick_coord(0), pick_coord(0), pick_coord(0), pick_coord(0));
        default: set_line(-65536, 65536, 131072, -32768);
      endcase
      if (phase == 6) idle_on = 1'b0;
      for (int cnt = 0; cnt < 60; ) begin
        int n;
        n = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 7);
        put_polygon(n, phase == 3 || $urandom_range(0, 5) == 0);
        cnt += n;
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
